@@ rtl/eanr_pkg.sv @@
// Shared types and constants for the ENQ/ACK/NAK frame receiver.
// Used by eanr_step and enq_ack_nak_frame_receiver_top; no dependencies.
package eanr_pkg;

    // Largest frame, counting the checksum byte.
    localparam int MAX_FRAME = 256;

    // Control characters on the serial link.
    localparam logic [7:0] CH_ENQ = 8'd5;
    localparam logic [7:0] CH_ACK = 8'd6;
    localparam logic [7:0] CH_NAK = 8'd21;

    // Sum of a length byte and its inverse in a good header.
    localparam logic [8:0] LEN_PAIR_SUM = 9'd255;

    // Configuration register indexes.
    localparam logic REG_READ_RETRY  = 1'b0;
    localparam logic REG_CHECK_RETRY = 1'b1;

    // Reset value of both retry limits.
    localparam logic [2:0] RETRY_RESET = 3'd3;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_BYTE    = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OUT_BUSY = 2'd0,
        OUT_OK   = 2'd1,
        OUT_ERR  = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [2:0] read_retry_limit;
        logic [2:0] check_retry_limit;
    } t_cfg;

    typedef struct packed {
        t_phase     phase;
        logic [8:0] block_count;
        logic [7:0] frame_length;
        logic [7:0] header_ack;
        logic [7:0] xor_sum;
        logic [2:0] read_tries;
        logic [2:0] check_tries;
    } t_state;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_value;
        logic       data_valid;
        logic [7:0] data_value;
        logic [7:0] data_index;
        logic       done_res;
        t_outcome   outcome;
    } t_result;

endpackage

@@ rtl/enq_ack_nak_frame_receiver_top.sv @@
// Top level of the ENQ/ACK/NAK frame receiver: input register, state and
// configuration registers, result register. Depends on eanr_pkg and eanr_step.
//
// Usage: each transfer on the slave stream carries a command in tuser
// (start, received byte, read timeout) and the received byte in tdata.
// Every accepted item yields exactly one result on the master stream:
// a control byte to transmit (ENQ, ACK or NAK), a payload byte with its
// index, and on the last item of an exchange tlast set with the outcome
// (success or communication error).
// A result passes through the input register and then the result register
// before it is offered on the master stream.
// Throughput is one item per cycle while the master side takes results; the
// combinational step logic between the two registers sets it.
// The configuration channel is always ready and writes the read and check
// retry limits; write it only while no item is in flight.
// Reset (synchronous, active low) empties both registers, returns the
// exchange to idle and sets both retry limits to 3.
// When the master side stalls, the result register holds its item, the
// input register keeps the next one, and s_axis_tready drops until the
// result is taken.
module enq_ack_nak_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    // Slave stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_value
    input  logic [1:0]  s_axis_tuser,  // [1:0] command
    // Master stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [0] tx_valid, [8:1] tx_value, [9] data_valid,
                                       // [17:10] data_value, [25:18] data_index,
                                       // [27:26] outcome, [31:28] zero
    output logic        m_axis_tlast   // done_res
);
    import eanr_pkg::*;

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    t_result    r_res;
    t_result    n_res;
    logic       r_in_valid;
    logic [1:0] r_in_cmd;
    logic [7:0] r_in_rx;
    logic       r_out_valid;
    logic       advance;

    // The step fires when an item waits and the result register is free.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.read_retry_limit  <= RETRY_RESET;
            r_cfg.check_retry_limit <= RETRY_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_READ_RETRY) begin
                r_cfg.read_retry_limit <= i_cfg_data;
            end else if (i_cfg_index == REG_CHECK_RETRY) begin
                r_cfg.check_retry_limit <= i_cfg_data;
            end
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd <= s_axis_tuser;
            r_in_rx  <= s_axis_tdata;
        end
    end

    eanr_step u_step (
        .i_cfg      (r_cfg),
        .i_state    (r_state),
        .i_command  (r_in_cmd),
        .i_rx_value (r_in_rx),
        .o_state    (n_state),
        .o_result   (n_res)
    );

    // Exchange state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_res.done_res;
    assign m_axis_tdata  = {4'b0000, r_res.outcome, r_res.data_index, r_res.data_value,
                            r_res.data_valid, r_res.tx_value, r_res.tx_valid};

endmodule

@@ rtl/eanr_step.sv @@
// Next-state and result logic for one received item of the exchange.
// Purely combinational; depends on eanr_pkg.
module eanr_step (
    input  eanr_pkg::t_cfg    i_cfg,
    input  eanr_pkg::t_state  i_state,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_rx_value,
    output eanr_pkg::t_state  o_state,
    output eanr_pkg::t_result o_result
);
    import eanr_pkg::*;

    localparam logic [9:0] MaxFrameW = 10'(MAX_FRAME);

    t_state   n_st;
    t_result  res;
    logic     do_bad;
    logic     do_finish;
    t_outcome fin_code;
    logic     hdr_good;

    // Header check: ACK first, length and inverse add to 255, frame fits.
    assign hdr_good = (i_state.header_ack == CH_ACK)
                   && ({1'b0, i_state.frame_length} + {1'b0, i_rx_value} == LEN_PAIR_SUM)
                   && ({2'b00, i_state.frame_length} + 10'd1 <= MaxFrameW);

    always_comb begin
        n_st      = i_state;
        res       = '0;
        do_bad    = 1'b0;
        do_finish = 1'b0;
        fin_code  = OUT_BUSY;

        unique case (t_cmd'(i_command))
            CMD_START: begin
                n_st.phase        = PH_HEADER;
                n_st.block_count  = '0;
                n_st.xor_sum      = '0;
                n_st.frame_length = '0;
                n_st.header_ack   = '0;
                n_st.read_tries   = '0;
                n_st.check_tries  = '0;
                res.tx_valid      = 1'b1;
                res.tx_value      = CH_ENQ;
            end
            CMD_TIMEOUT: begin
                if (i_state.phase != PH_IDLE) begin
                    // Timeout on the last allowed attempt gives up.
                    if ({1'b0, i_state.read_tries} + 4'd1 >= {1'b0, i_cfg.read_retry_limit}) begin
                        do_finish = 1'b1;
                        fin_code  = OUT_ERR;
                    end else begin
                        n_st.read_tries  = i_state.read_tries + 3'd1;
                        n_st.block_count = '0;
                        n_st.xor_sum     = '0;
                        res.tx_valid     = 1'b1;
                        res.tx_value     = (i_state.phase == PH_HEADER
                                            && i_state.check_tries == 3'd0) ? CH_ENQ : CH_NAK;
                    end
                end
            end
            CMD_BYTE: begin
                if (i_state.phase == PH_HEADER) begin
                    // Header bytes: ACK, length, inverted length.
                    if (i_state.block_count == 9'd0) begin
                        n_st.header_ack  = i_rx_value;
                        n_st.block_count = 9'd1;
                    end else if (i_state.block_count == 9'd1) begin
                        n_st.frame_length = i_rx_value;
                        n_st.block_count  = 9'd2;
                    end else if (hdr_good) begin
                        n_st.phase       = PH_DATA;
                        n_st.block_count = '0;
                        n_st.xor_sum     = '0;
                        n_st.read_tries  = '0;
                        n_st.check_tries = '0;
                        res.tx_valid     = 1'b1;
                        res.tx_value     = CH_ACK;
                    end else begin
                        do_bad = 1'b1;
                    end
                end else if (i_state.phase == PH_DATA) begin
                    // Payload bytes, then the checksum byte.
                    if (i_state.block_count < {1'b0, i_state.frame_length}) begin
                        res.data_valid   = 1'b1;
                        res.data_value   = i_rx_value;
                        res.data_index   = i_state.block_count[7:0];
                        n_st.xor_sum     = i_state.xor_sum ^ i_rx_value;
                        n_st.block_count = i_state.block_count + 9'd1;
                    end else if (i_rx_value == i_state.xor_sum) begin
                        do_finish    = 1'b1;
                        fin_code     = OUT_OK;
                        res.tx_valid = 1'b1;
                        res.tx_value = CH_ACK;
                    end else begin
                        do_bad = 1'b1;
                    end
                end
            end
            CMD_NONE: begin
                // Unused command: nothing changes.
            end
            default: begin
            end
        endcase

        // Bad header or checksum: NAK and reread, or give up.
        if (do_bad) begin
            if (i_state.check_tries >= i_cfg.check_retry_limit) begin
                do_finish = 1'b1;
                fin_code  = OUT_ERR;
            end else begin
                n_st.check_tries = i_state.check_tries + 3'd1;
                n_st.read_tries  = '0;
                n_st.block_count = '0;
                n_st.xor_sum     = '0;
                res.tx_valid     = 1'b1;
                res.tx_value     = CH_NAK;
            end
        end

        // End of the exchange.
        if (do_finish) begin
            n_st.phase       = PH_IDLE;
            n_st.block_count = '0;
            n_st.xor_sum     = '0;
            res.done_res     = 1'b1;
            res.outcome      = fin_code;
        end
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule
